// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is high.
`define TWA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds through reset.
`define TWA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/twa_pkg.sv =====
package twa_pkg;

  // Field widths and configuration port shape.
  localparam int FIELD_W        = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CFG_IDX_W      = 3;

  typedef logic signed [FIELD_W-1:0] twa_word_t;
  // A 32 x 32 product reduced to 30 fraction bits.
  typedef logic signed [33:0]        twa_prod30_t;
  // A sum of three reduced products.
  typedef logic signed [35:0]        twa_sum_t;
  // A 32 x 32 product reduced to 16 fraction bits.
  typedef logic signed [47:0]        twa_prod16_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_QW  = 3'd0,
    REG_ROT_QX  = 3'd1,
    REG_ROT_QY  = 3'd2,
    REG_ROT_QZ  = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } twa_reg_t;

  // One in Q2.30.
  localparam twa_word_t Q30_ONE = 32'sh4000_0000;

  typedef struct packed {
    twa_word_t vel_x;
    twa_word_t vel_y;
    twa_word_t vel_z;
    twa_word_t spin_x;
    twa_word_t spin_y;
    twa_word_t spin_z;
  } twa_in_t;

  typedef struct packed {
    twa_word_t out_vel_x;
    twa_word_t out_vel_y;
    twa_word_t out_vel_z;
    twa_word_t out_spin_x;
    twa_word_t out_spin_y;
    twa_word_t out_spin_z;
    logic      clipped;
  } twa_out_t;

  typedef struct packed {
    twa_word_t qw;
    twa_word_t qx;
    twa_word_t qy;
    twa_word_t qz;
  } twa_quat_t;

  typedef struct packed {
    twa_word_t x;
    twa_word_t y;
    twa_word_t z;
  } twa_vec_t;

  // Rotation matrix in row-major order, plus the twist it is applied to.
  typedef struct packed {
    twa_word_t [8:0] r;
    twa_word_t [2:0] vel;
    twa_word_t [2:0] spin;
  } twa_rot_t;

  // Rotated linear part (unsaturated), saturated rotated angular part.
  typedef struct packed {
    twa_sum_t  [2:0] rv;
    twa_word_t [2:0] rw;
    logic            clip;
  } twa_turn_t;

  // Full signed product of two words.
  function automatic logic signed [63:0] smul(input twa_word_t a, input twa_word_t b);
    logic signed [63:0] p;
    p = a * b;
    return p;
  endfunction

  // Round half up to 30 fraction bits fewer.
  function automatic twa_prod30_t rnd30(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd536870912;
    return s[63:30];
  endfunction

  // Round half up to 16 fraction bits fewer.
  function automatic twa_prod16_t rnd16(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd32768;
    return s[63:16];
  endfunction

endpackage

// ===== design/twa_quat.sv =====
module twa_quat (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  twa_pkg::twa_in_t   in_data,
  input  twa_pkg::twa_quat_t quat,
  output logic               out_valid,
  input  logic               out_ready,
  output twa_pkg::twa_rot_t  out_data
);
  import twa_pkg::*;

  localparam logic signed [37:0] ONE38 = 38'sh0_4000_0000;
  localparam logic signed [37:0] RMAX  = 38'sd2147483647;
  localparam logic signed [37:0] RMIN  = -38'sd2147483648;

  logic            s1_ready;
  logic            s2_ready;
  logic            v1;
  twa_prod30_t     xx, yy, zz, xy, xz, yz, wx, wy, wz;
  twa_word_t [2:0] vel1;
  twa_word_t [2:0] spin1;
  logic signed [37:0] raw [9];
  twa_word_t [8:0] r_next;

  // Each stage moves on when it is empty or the next one takes its item.
  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !v1 || s2_ready;
  assign in_ready = s1_ready;

  // Stage one: quaternion component products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      xx    <= rnd30(smul(quat.qx, quat.qx));
      yy    <= rnd30(smul(quat.qy, quat.qy));
      zz    <= rnd30(smul(quat.qz, quat.qz));
      xy    <= rnd30(smul(quat.qx, quat.qy));
      xz    <= rnd30(smul(quat.qx, quat.qz));
      yz    <= rnd30(smul(quat.qy, quat.qz));
      wx    <= rnd30(smul(quat.qw, quat.qx));
      wy    <= rnd30(smul(quat.qw, quat.qy));
      wz    <= rnd30(smul(quat.qw, quat.qz));
      vel1  <= {in_data.vel_z, in_data.vel_y, in_data.vel_x};
      spin1 <= {in_data.spin_z, in_data.spin_y, in_data.spin_x};
    end
  end

  // Stage two: matrix entries, each held to the Q2.30 register range.
  always_comb begin
    raw[0] = ONE38 - ((38'(yy) + 38'(zz)) <<< 1);
    raw[1] = (38'(xy) - 38'(wz)) <<< 1;
    raw[2] = (38'(xz) + 38'(wy)) <<< 1;
    raw[3] = (38'(xy) + 38'(wz)) <<< 1;
    raw[4] = ONE38 - ((38'(xx) + 38'(zz)) <<< 1);
    raw[5] = (38'(yz) - 38'(wx)) <<< 1;
    raw[6] = (38'(xz) - 38'(wy)) <<< 1;
    raw[7] = (38'(yz) + 38'(wx)) <<< 1;
    raw[8] = ONE38 - ((38'(xx) + 38'(yy)) <<< 1);
    for (int k = 0; k < 9; k++) begin
      priority if (raw[k] > RMAX) begin
        r_next[k] = RMAX[31:0];
      end else if (raw[k] < RMIN) begin
        r_next[k] = RMIN[31:0];
      end else begin
        r_next[k] = raw[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      out_data.r    <= r_next;
      out_data.vel  <= vel1;
      out_data.spin <= spin1;
    end
  end

endmodule

// ===== design/twa_rotate.sv =====
module twa_rotate #(
  parameter int DATA_WIDTH = twa_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  twa_pkg::twa_rot_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output twa_pkg::twa_turn_t out_data
);
  import twa_pkg::*;

  localparam int EFF_W = (DATA_WIDTH > FIELD_W) ? FIELD_W :
                         ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
  localparam twa_sum_t SUM_HI = (36'sd1 <<< (EFF_W - 1)) - 36'sd1;
  localparam twa_sum_t SUM_LO = -SUM_HI - 36'sd1;

  logic            s1_ready;
  logic            s2_ready;
  logic            v1;
  twa_prod30_t     rvp [9];
  twa_prod30_t     rwp [9];
  twa_sum_t  [2:0] rv_next;
  twa_sum_t        rw_sum [3];
  twa_word_t [2:0] rw_next;
  logic      [2:0] hit;

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !v1 || s2_ready;
  assign in_ready = s1_ready;

  // Stage three: the eighteen matrix-vector products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rvp[3*i+j] <= rnd30(smul(in_data.r[3*i+j], in_data.vel[j]));
          rwp[3*i+j] <= rnd30(smul(in_data.r[3*i+j], in_data.spin[j]));
        end
      end
    end
  end

  // Stage four: row sums; the angular part is saturated here since the
  // cross product uses the saturated value.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rv_next[i] = 36'(rvp[3*i]) + 36'(rvp[3*i+1]) + 36'(rvp[3*i+2]);
      rw_sum[i]  = 36'(rwp[3*i]) + 36'(rwp[3*i+1]) + 36'(rwp[3*i+2]);
      priority if (rw_sum[i] > SUM_HI) begin
        rw_next[i] = SUM_HI[31:0];
        hit[i]     = 1'b1;
      end else if (rw_sum[i] < SUM_LO) begin
        rw_next[i] = SUM_LO[31:0];
        hit[i]     = 1'b1;
      end else begin
        rw_next[i] = rw_sum[i][31:0];
        hit[i]     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      out_data.rv   <= rv_next;
      out_data.rw   <= rw_next;
      out_data.clip <= |hit;
    end
  end

endmodule

// ===== design/twa_cross.sv =====
module twa_cross #(
  parameter int DATA_WIDTH = twa_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  twa_pkg::twa_turn_t in_data,
  input  twa_pkg::twa_vec_t  shift,
  output logic               out_valid,
  input  logic               out_ready,
  output twa_pkg::twa_out_t  out_data
);
  import twa_pkg::*;

  localparam int EFF_W = (DATA_WIDTH > FIELD_W) ? FIELD_W :
                         ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
  localparam logic signed [49:0] LIN_HI = (50'sd1 <<< (EFF_W - 1)) - 50'sd1;
  localparam logic signed [49:0] LIN_LO = -LIN_HI - 50'sd1;

  logic            s1_ready;
  logic            s2_ready;
  logic            v1;
  twa_prod16_t     cp [6];
  twa_sum_t  [2:0] rv1;
  twa_word_t [2:0] rw1;
  logic            clip1;
  logic signed [49:0] lin [3];
  twa_word_t [2:0] lin_next;
  logic      [2:0] hit;

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !v1 || s2_ready;
  assign in_ready = s1_ready;

  // Stage five: the six products of the translation cross product.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      cp[0] <= rnd16(smul(shift.y, in_data.rw[2]));
      cp[1] <= rnd16(smul(shift.z, in_data.rw[1]));
      cp[2] <= rnd16(smul(shift.z, in_data.rw[0]));
      cp[3] <= rnd16(smul(shift.x, in_data.rw[2]));
      cp[4] <= rnd16(smul(shift.x, in_data.rw[1]));
      cp[5] <= rnd16(smul(shift.y, in_data.rw[0]));
      rv1   <= in_data.rv;
      rw1   <= in_data.rw;
      clip1 <= in_data.clip;
    end
  end

  // Stage six: add the cross product to the rotated linear part and saturate.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lin[i] = 50'(rv1[i]) + 50'(cp[2*i]) - 50'(cp[2*i+1]);
      priority if (lin[i] > LIN_HI) begin
        lin_next[i] = LIN_HI[31:0];
        hit[i]      = 1'b1;
      end else if (lin[i] < LIN_LO) begin
        lin_next[i] = LIN_LO[31:0];
        hit[i]      = 1'b1;
      end else begin
        lin_next[i] = lin[i][31:0];
        hit[i]      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      out_data.out_vel_x  <= lin_next[0];
      out_data.out_vel_y  <= lin_next[1];
      out_data.out_vel_z  <= lin_next[2];
      out_data.out_spin_x <= rw1[0];
      out_data.out_spin_y <= rw1[1];
      out_data.out_spin_z <= rw1[2];
      out_data.clipped    <= clip1 | (|hit);
    end
  end

endmodule

// ===== design/twist_adjoint_transform.sv =====
// Rigid-body adjoint transform of a twist. Each item carries a linear and an
// angular velocity in signed Q16.16; the block rotates both by the matrix
// built from the configured quaternion (Q2.30, used as written, not
// normalised) and adds the translation crossed with the rotated angular
// velocity to the linear part. Outputs saturate to DATA_WIDTH bits (16 to 32
// effective) and clipped is set when any component saturated. The datapath is
// a six-stage pipeline: quaternion products, matrix entries, eighteen
// matrix-vector multiplies, row sums, cross-product multiplies, final sum.
// One item is accepted every cycle while the output is not stalled. Register
// writes are to be made only while no item is in flight, so that they apply to
// items accepted after the write; the block itself does not enforce this.
module twist_adjoint_transform #(
  parameter int DATA_WIDTH = twa_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           twist_valid,
  output logic                           twist_stall,
  input  twa_pkg::twa_in_t               twist,
  output logic                           result_valid,
  input  logic                           result_stall,
  output twa_pkg::twa_out_t              result,
  input  logic                           cfg_wen,
  input  logic [twa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [twa_pkg::FIELD_W-1:0]    cfg_data
);
  import twa_pkg::*;

  twa_quat_t quat;
  twa_vec_t  shift;
  logic      quat_ready;
  logic      rot_valid;
  logic      rot_ready;
  twa_rot_t  rot_data;
  logic      turn_valid;
  logic      turn_ready;
  twa_turn_t turn_data;

  // Configuration registers; writes beyond the last index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      quat  <= '{qw: Q30_ONE, qx: '0, qy: '0, qz: '0};
      shift <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        REG_ROT_QW:  quat.qw  <= cfg_data;
        REG_ROT_QX:  quat.qx  <= cfg_data;
        REG_ROT_QY:  quat.qy  <= cfg_data;
        REG_ROT_QZ:  quat.qz  <= cfg_data;
        REG_SHIFT_X: shift.x  <= cfg_data;
        REG_SHIFT_Y: shift.y  <= cfg_data;
        REG_SHIFT_Z: shift.z  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign twist_stall = !quat_ready;

  // Rotation matrix from the quaternion.
  twa_quat u_quat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (twist_valid),
    .in_ready  (quat_ready),
    .in_data   (twist),
    .quat      (quat),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_data  (rot_data)
  );

  // Rotation of both velocity vectors.
  twa_rotate #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_data   (rot_data),
    .out_valid (turn_valid),
    .out_ready (turn_ready),
    .out_data  (turn_data)
  );

  // Translation cross product and output register.
  twa_cross #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (turn_valid),
    .in_ready  (turn_ready),
    .in_data   (turn_data),
    .shift     (shift),
    .out_valid (result_valid),
    .out_ready (!result_stall),
    .out_data  (result)
  );

endmodule

// ===== design/twa_checker.sv =====
`include "assert_macros.svh"

module twa_checker (
  input logic              clk,
  input logic              rst,
  input logic              twist_stall,
  input logic              result_valid,
  input logic              result_stall,
  input twa_pkg::twa_out_t result
);
  import twa_pkg::*;

  // A stalled result stays offered and unchanged.
  `TWA_ASSERT(a_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

  // A result is withdrawn only after it has been taken.
  `TWA_ASSERT(a_taken, clk, rst, $fell(result_valid) && !$past(rst) |-> $past(!result_stall), "result dropped")

  // Reset empties the pipeline.
  `TWA_ASSERT_NR(a_reset, clk, rst |=> !result_valid, "result offered after reset")

  // With the output free every stage moves, so the input is never held off.
  `TWA_ASSERT(a_flow, clk, rst, !result_stall |-> !twist_stall, "input stalled with output free")

endmodule

bind twist_adjoint_transform twa_checker u_twa_checker (.*);

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twa_pkg::*;

  localparam int DATA_WIDTH = DATA_WIDTH_DEF;
  // Outputs saturate to this many bits; the fields themselves are 32 bits wide.
  localparam int OUT_W = DATA_WIDTH > 32 ? 32 : (DATA_WIDTH < 16 ? 16 : DATA_WIDTH);
  localparam int REG_COUNT = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int LATENCY = 6;
  localparam int HOLD_CYCLES = 120;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] Q16_ONE = 32'h0001_0000;
  localparam logic [31:0] Q30_HALF_SQRT2 = 32'd759250125;

  typedef enum int {FLOW, LIGHT, HEAVY, TOGGLE} stall_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic twist_valid = 1'b0;
  logic twist_stall;
  twa_in_t twist = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  twa_out_t result;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [FIELD_W-1:0] cfg_data = '0;

  // Copy of the configuration registers as the block should hold them.
  logic signed [31:0] reg_copy [REG_COUNT];

  twa_in_t pending_twists [$];
  twa_out_t expected_results [$];
  twa_out_t want;

  bit twist_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mode_left = 0;
  stall_mode_t stall_mode = FLOW;

  int errors = 0;
  int twists_sent = 0;
  int results_checked = 0;
  int clipped_seen = 0;
  int settings_applied = 0;

  twist_adjoint_transform #(.DATA_WIDTH(DATA_WIDTH)) uut (
    .clk         (clk),
    .rst         (rst),
    .twist_valid (twist_valid),
    .twist_stall (twist_stall),
    .twist       (twist),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_wen     (cfg_wen),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round half up: add half an LSB of the target, then floor.
  function automatic longint round_shift(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint saturate(longint x, longint lo, longint hi, inout bit hit);
    if (x > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (x < lo) begin
      hit = 1'b1;
      return lo;
    end
    return x;
  endfunction

  // Adjoint transform of one twist under the current register copy.
  function automatic twa_out_t predict_twist(twa_in_t tw);
    longint one, qw, qx, qy, qz;
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    longint sh [3];
    longint v [3];
    longint w [3];
    longint rot [3][3];
    longint rv [3];
    longint rw [3];
    longint lin [3];
    longint rot_hi, rot_lo, out_hi, out_lo;
    bit clip, unused;
    int i, j;
    twa_out_t res;
    one = longint'(Q30_ONE);
    qw = reg_copy[REG_ROT_QW];
    qx = reg_copy[REG_ROT_QX];
    qy = reg_copy[REG_ROT_QY];
    qz = reg_copy[REG_ROT_QZ];
    sh[0] = reg_copy[REG_SHIFT_X];
    sh[1] = reg_copy[REG_SHIFT_Y];
    sh[2] = reg_copy[REG_SHIFT_Z];
    v[0] = tw.vel_x;
    v[1] = tw.vel_y;
    v[2] = tw.vel_z;
    w[0] = tw.spin_x;
    w[1] = tw.spin_y;
    w[2] = tw.spin_z;

    // Quaternion products in Q.30, then the rotation matrix.
    xx = round_shift(qx * qx, 30);
    yy = round_shift(qy * qy, 30);
    zz = round_shift(qz * qz, 30);
    xy = round_shift(qx * qy, 30);
    xz = round_shift(qx * qz, 30);
    yz = round_shift(qy * qz, 30);
    wx = round_shift(qw * qx, 30);
    wy = round_shift(qw * qy, 30);
    wz = round_shift(qw * qz, 30);
    rot[0][0] = one - 2 * (yy + zz);
    rot[0][1] = 2 * (xy - wz);
    rot[0][2] = 2 * (xz + wy);
    rot[1][0] = 2 * (xy + wz);
    rot[1][1] = one - 2 * (xx + zz);
    rot[1][2] = 2 * (yz - wx);
    rot[2][0] = 2 * (xz - wy);
    rot[2][1] = 2 * (yz + wx);
    rot[2][2] = one - 2 * (xx + yy);

    // A non-unit quaternion can push entries past the Q2.30 range.
    rot_hi = (longint'(1) <<< 31) - 1;
    rot_lo = -rot_hi - 1;
    out_hi = (longint'(1) <<< (OUT_W - 1)) - 1;
    out_lo = -out_hi - 1;
    clip = 1'b0;
    unused = 1'b0;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        rot[i][j] = saturate(rot[i][j], rot_lo, rot_hi, unused);

    for (i = 0; i < 3; i++) begin
      rv[i] = 0;
      rw[i] = 0;
      for (j = 0; j < 3; j++) begin
        rv[i] += round_shift(rot[i][j] * v[j], 30);
        rw[i] += round_shift(rot[i][j] * w[j], 30);
      end
      rw[i] = saturate(rw[i], out_lo, out_hi, clip);
    end

    // The translation is crossed with the already saturated R*w.
    lin[0] = rv[0] + round_shift(sh[1] * rw[2], 16) - round_shift(sh[2] * rw[1], 16);
    lin[1] = rv[1] + round_shift(sh[2] * rw[0], 16) - round_shift(sh[0] * rw[2], 16);
    lin[2] = rv[2] + round_shift(sh[0] * rw[1], 16) - round_shift(sh[1] * rw[0], 16);
    for (i = 0; i < 3; i++)
      lin[i] = saturate(lin[i], out_lo, out_hi, clip);

    res.out_vel_x  = lin[0][31:0];
    res.out_vel_y  = lin[1][31:0];
    res.out_vel_z  = lin[2][31:0];
    res.out_spin_x = rw[0][31:0];
    res.out_spin_y = rw[1][31:0];
    res.out_spin_z = rw[2][31:0];
    res.clipped    = clip;
    return res;
  endfunction

  // Field values: full range, small magnitudes, extremes and a few LSBs.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6, 7: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      8: begin
        case ($urandom_range(3))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(6) - 3;
    endcase
  endfunction

  function automatic twa_in_t random_twist();
    twa_in_t tw;
    tw.vel_x  = rand_word();
    tw.vel_y  = rand_word();
    tw.vel_z  = rand_word();
    tw.spin_x = rand_word();
    tw.spin_y = rand_word();
    tw.spin_z = rand_word();
    return tw;
  endfunction

  function automatic twa_in_t make_twist(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                         logic [31:0] d, logic [31:0] e, logic [31:0] f);
    twa_in_t tw;
    tw.vel_x  = a;
    tw.vel_y  = b;
    tw.vel_z  = c;
    tw.spin_x = d;
    tw.spin_y = e;
    tw.spin_z = f;
    return tw;
  endfunction

  // Corner twists: zero, extremes, rounding around zero and unit values.
  task automatic push_corner_twists();
    pending_twists.push_back(make_twist('0, '0, '0, '0, '0, '0));
    pending_twists.push_back(make_twist(WORD_MAX, WORD_MAX, WORD_MAX,
                                        WORD_MAX, WORD_MAX, WORD_MAX));
    pending_twists.push_back(make_twist(WORD_MIN, WORD_MIN, WORD_MIN,
                                        WORD_MIN, WORD_MIN, WORD_MIN));
    pending_twists.push_back(make_twist('1, '1, '1, '1, '1, '1));
    pending_twists.push_back(make_twist(1, 1, 1, 1, 1, 1));
    pending_twists.push_back(make_twist(WORD_MAX, WORD_MIN, WORD_MAX,
                                        WORD_MIN, WORD_MAX, WORD_MIN));
    pending_twists.push_back(make_twist(WORD_MIN, WORD_MAX, WORD_MIN,
                                        WORD_MAX, WORD_MIN, WORD_MAX));
    pending_twists.push_back(make_twist(Q16_ONE, -Q16_ONE, Q16_ONE >> 1,
                                        -(Q16_ONE >> 1), 1, Q16_ONE));
  endtask

  // One register write on the configuration port; the block is idle here.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_wen  <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (idx < REG_COUNT)
      reg_copy[idx] = data;
  endtask

  task automatic apply_setting(input logic [31:0] qw, input logic [31:0] qx,
                               input logic [31:0] qy, input logic [31:0] qz,
                               input logic [31:0] sx, input logic [31:0] sy,
                               input logic [31:0] sz);
    write_reg(REG_ROT_QW, qw);
    write_reg(REG_ROT_QX, qx);
    write_reg(REG_ROT_QY, qy);
    write_reg(REG_ROT_QZ, qz);
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_SHIFT_Z, sz);
    settings_applied++;
  endtask

  // Random pose: a unit, an arbitrary or an extreme quaternion, and a shift.
  task automatic random_setting();
    logic [31:0] q [4];
    logic [31:0] s [3];
    real a [4];
    real norm;
    int k;
    int qmode, smode;
    qmode = $urandom_range(2);
    smode = $urandom_range(2);
    norm = 0.0;
    for (k = 0; k < 4; k++) begin
      a[k] = $urandom_range(2_000_000) / 1.0e6 - 1.0;
      norm += a[k] * a[k];
    end
    norm = $sqrt(norm);
    if (norm < 1.0e-3) begin
      a[0] = 1.0;
      norm = 1.0;
    end
    for (k = 0; k < 4; k++) begin
      case (qmode)
        0: q[k] = $rtoi(a[k] / norm * 1073741824.0);
        1: q[k] = $urandom_range(32'h8000_0000) - 32'h4000_0000;
        default: q[k] = (int'($urandom_range(2)) - 1) * Q30_ONE;
      endcase
    end
    for (k = 0; k < 3; k++) begin
      case (smode)
        0: s[k] = $urandom_range(32'h0020_0000) - 32'h0010_0000;
        1: s[k] = $urandom();
        default: begin
          case ($urandom_range(2))
            0: s[k] = WORD_MAX;
            1: s[k] = WORD_MIN;
            default: s[k] = '0;
          endcase
        end
      endcase
    end
    apply_setting(q[0], q[1], q[2], q[3], s[0], s[1], s[2]);
  endtask

  task automatic wait_drained();
    while (pending_twists.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      twist_valid <= 1'b0;
    end else if (twist_valid && !twist_taken) begin
      // The offered item is still waiting; leave it untouched.
    end else if (gap_left > 0) begin
      twist_valid <= 1'b0;
      gap_left--;
    end else if (pending_twists.size() > 0) begin
      twist_valid <= 1'b1;
      twist <= pending_twists[0];
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      twist_valid <= 1'b0;
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus long hold-offs.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(3));
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        case (stall_mode)
          FLOW: result_stall <= 1'b0;
          LIGHT: result_stall <= ($urandom_range(3) == 0);
          HEAVY: result_stall <= ($urandom_range(3) != 0);
          default: result_stall <= !result_stall;
        endcase
      end
    end
  end

  // Record accepted twists with their predicted results and check each result.
  always @(posedge clk) begin
    if (rst) begin
      twist_taken = 1'b0;
    end else begin
      twist_taken = twist_valid && !twist_stall;
      if (twist_taken) begin
        expected_results.push_back(predict_twist(twist));
        if (pending_twists.size() > 0)
          void'(pending_twists.pop_front());
        twists_sent++;
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, result);
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("out_vel_x", want.out_vel_x, result.out_vel_x);
          compare_field("out_vel_y", want.out_vel_y, result.out_vel_y);
          compare_field("out_vel_z", want.out_vel_z, result.out_vel_z);
          compare_field("out_spin_x", want.out_spin_x, result.out_spin_x);
          compare_field("out_spin_y", want.out_spin_y, result.out_spin_y);
          compare_field("out_spin_z", want.out_spin_z, result.out_spin_z);
          compare_field("clipped", {31'b0, want.clipped}, {31'b0, result.clipped});
          results_checked++;
          if (want.clipped)
            clipped_seen++;
        end
      end
    end
  end

  // Stimulus: corner twists under three fixed poses, then random phases.
  initial begin
    int phase;
    reg_copy[REG_ROT_QW] = Q30_ONE;
    reg_copy[REG_ROT_QX] = '0;
    reg_copy[REG_ROT_QY] = '0;
    reg_copy[REG_ROT_QZ] = '0;
    reg_copy[REG_SHIFT_X] = '0;
    reg_copy[REG_SHIFT_Y] = '0;
    reg_copy[REG_SHIFT_Z] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Identity pose straight out of reset.
    push_corner_twists();
    wait_drained();

    // Quarter turn about z with a fractional shift.
    apply_setting(Q30_HALF_SQRT2, '0, '0, Q30_HALF_SQRT2,
                  32'h0001_8000, 32'hfffe_0000, 32'h0000_4000);
    push_corner_twists();
    wait_drained();

    // Non-unit quaternion saturates matrix entries; shift at its extremes.
    apply_setting(Q30_ONE, Q30_ONE, Q30_ONE, Q30_ONE, WORD_MAX, WORD_MIN, WORD_MAX);
    push_corner_twists();
    wait_drained();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES - 1)
        apply_setting(Q30_ONE, '0, '0, '0, '0, '0, '0);
      else
        random_setting();
      // A write to an unused index must leave the pose alone.
      write_reg(CFG_IDX_UNUSED, $urandom());
      repeat (ITEMS_PER_PHASE) pending_twists.push_back(random_twist());
      // Hold the output off while the sender keeps offering, to back up the pipeline.
      if (phase == 2)
        hold_requests++;
      wait_drained();
    end
    repeat (LATENCY + 6) @(posedge clk);

    $display("Run covered %0d twists under %0d register settings, %0d results checked.",
             twists_sent, settings_applied + 1, results_checked);
    $display("Saturated results: %0d; corner poses, non-unit quaternions and unused index.",
             clipped_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding.", expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
